@@ rtl/mms_pkg.sv @@
// Shared types, widths and codes for the masked mean and deviation block.
`timescale 1ns / 1ps

package mms_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int VAL_W       = SAMPLE_BITS + 1;
  localparam int MAG_W       = SAMPLE_BITS;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int CNT_W       = 17;
  localparam int SUM_W       = 34;
  localparam int SSQ_W       = 49;
  localparam int PROD_W      = CNT_W + SSQ_W + 1;
  localparam int MCAND_W     = SSQ_W;
  localparam int MPLR_W      = SUM_W;
  localparam int VAR_SHIFT   = 16;
  localparam int MEAN_SHIFT  = 8;
  localparam int DNUM_W      = PROD_W + VAR_SHIFT;
  localparam int DDEN_W      = 2 * CNT_W;
  localparam int ROOT_W      = 64;
  localparam int MEAN_W      = 25;
  localparam int SD_W        = 24;
  localparam int STATUS_W    = 2;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam int MUL_STEPS   = MPLR_W;
  localparam int DIV_STEPS   = DNUM_W;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0]        MAX_COUNT = CNT_W'(65536);
  localparam logic signed [SUM_W-1:0] SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [SD_W-1:0]         MEAN_LIM  = SD_W'(16776960);
  localparam logic [SD_W-1:0]         SD_LIM    = SD_W'(16776960);

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SINGLE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVF    = 2'd3;

  localparam logic REG_USE_DIFF   = 1'b0;
  localparam logic REG_SAMPLE_DIV = 1'b1;

  typedef enum logic [3:0] {
    S_ACCUM,
    S_PREP,
    S_MUL_A,
    S_MUL_B,
    S_MUL_C,
    S_DIV_M,
    S_DIV_V,
    S_ROOT,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MUL_NS2,
    MUL_S1S1,
    MUL_ND
  } mul_sel_t;

  typedef enum logic {
    DIV_MEAN,
    DIV_VAR
  } div_sel_t;

  typedef struct packed {
    logic     accum;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     cap_p1;
    logic     cap_p2;
    logic     cap_p3;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_mean;
    logic     root_start;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic root_busy;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/mms_ctrl.sv @@
// Sequencer that steps the accumulate, multiply, divide and root phases.
`timescale 1ns / 1ps

module mms_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tlast,
  input  mms_pkg::sts_t sts,
  output logic          in_tready,
  output mms_pkg::cmd_t cmd
);
  import mms_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACCUM;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_ACCUM: begin
        if (in_tvalid && in_tlast) state_nxt = S_PREP;
      end
      S_PREP:  state_nxt = S_MUL_A;
      S_MUL_A: begin
        if (!sts.mul_busy) state_nxt = S_MUL_B;
      end
      S_MUL_B: begin
        if (!sts.mul_busy) state_nxt = S_MUL_C;
      end
      S_MUL_C: begin
        if (!sts.mul_busy) state_nxt = S_DIV_M;
      end
      S_DIV_M: begin
        if (!sts.div_busy) state_nxt = S_DIV_V;
      end
      S_DIV_V: begin
        if (!sts.div_busy) state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (!sts.root_busy) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_ACCUM;
      end
      default: state_nxt = S_ACCUM;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_ACCUM: begin
        in_tready = 1'b1;
        cmd.accum = in_tvalid;
      end
      S_PREP: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_NS2;
      end
      S_MUL_A: begin
        if (!sts.mul_busy) begin
          cmd.cap_p1    = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_S1S1;
        end
      end
      S_MUL_B: begin
        if (!sts.mul_busy) begin
          cmd.cap_p2    = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_ND;
        end
      end
      S_MUL_C: begin
        if (!sts.mul_busy) begin
          cmd.cap_p3    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_MEAN;
        end
      end
      S_DIV_M: begin
        if (!sts.div_busy) begin
          cmd.cap_mean  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_VAR;
        end
      end
      S_DIV_V: begin
        cmd.root_start = !sts.div_busy;
      end
      S_ROOT: begin
        cmd.emit = 1'b0;
      end
      S_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/mms_dp.sv @@
// Datapath: accumulators, shift-add multiplier, restoring divider, root and output register.
`timescale 1ns / 1ps

module mms_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mms_pkg::cmd_t                        cmd,
  output mms_pkg::sts_t                        sts,
  input  logic                                 use_diff,
  input  logic                                 sample_div,
  input  logic signed [mms_pkg::SAMPLE_BITS-1:0] first_value,
  input  logic signed [mms_pkg::SAMPLE_BITS-1:0] second_value,
  input  logic                                 include_req,
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic signed [mms_pkg::MEAN_W-1:0]    mean_out,
  output logic [mms_pkg::SD_W-1:0]             stddev_out,
  output logic [mms_pkg::CNT_W-1:0]            count_out,
  output logic [mms_pkg::STATUS_W-1:0]         status
);
  import mms_pkg::*;

  // accumulators
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [SSQ_W-1:0]        ssq_r;
  logic [SSQ_W-1:0]        ssq_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic                    ovf_r;

  logic signed [VAL_W-1:0] val;
  logic [MAG_W-1:0]        val_mag;
  logic [SQ_W-1:0]         val_sq;
  logic signed [SUM_W:0]   sum_ext;
  logic [SSQ_W:0]          ssq_ext;

  always_comb begin
    if (use_diff) begin
      val = VAL_W'(first_value) - VAL_W'(second_value);
    end else begin
      val = VAL_W'(first_value);
    end
    val_mag = val[VAL_W-1] ? MAG_W'(-val) : MAG_W'(val);
    val_sq  = SQ_W'(val_mag) * SQ_W'(val_mag);
    sum_ext = (SUM_W+1)'(sum_r) + (SUM_W+1)'(val);
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_nxt = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_nxt = sum_ext[SUM_W-1:0];
    end
    ssq_ext = {1'b0, ssq_r} + (SSQ_W+1)'(val_sq);
    ssq_nxt = ssq_ext[SSQ_W] ? {SSQ_W{1'b1}} : ssq_ext[SSQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      sum_r <= '0;
      ssq_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.accum && include_req) begin
      if (cnt_r >= MAX_COUNT) begin
        ovf_r <= 1'b1;
      end else begin
        sum_r <= sum_nxt;
        ssq_r <= ssq_nxt;
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  logic                sum_neg;
  logic [SUM_W-1:0]    sum_mag;
  logic [CNT_W-1:0]    den_n;

  assign sum_neg = sum_r[SUM_W-1];
  assign sum_mag = sum_neg ? $unsigned(-sum_r) : $unsigned(sum_r);
  assign den_n   = sample_div ? cnt_r - CNT_W'(1) : cnt_r;

  // shift-add multiplier, multiplier bits taken MSB first
  logic [PROD_W-1:0]    mul_acc_r;
  logic [MCAND_W-1:0]   mul_cand_r;
  logic [MPLR_W-1:0]    mul_plier_r;
  logic [MUL_CNT_W-1:0] mul_cnt_r;
  logic                 mul_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_cnt_r  <= '0;
    end else if (cmd.mul_start) begin
      mul_busy_r <= 1'b1;
      mul_cnt_r  <= '0;
    end else if (mul_busy_r) begin
      mul_cnt_r <= mul_cnt_r + MUL_CNT_W'(1);
      if (mul_cnt_r == MUL_CNT_W'(MUL_STEPS - 1)) mul_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mul_acc_r <= '0;
      unique case (cmd.mul_sel)
        MUL_NS2: begin
          mul_cand_r  <= ssq_r;
          mul_plier_r <= MPLR_W'(cnt_r);
        end
        MUL_S1S1: begin
          mul_cand_r  <= MCAND_W'(sum_mag);
          mul_plier_r <= sum_mag;
        end
        MUL_ND: begin
          mul_cand_r  <= MCAND_W'(cnt_r);
          mul_plier_r <= MPLR_W'(den_n);
        end
        default: begin
          mul_cand_r  <= '0;
          mul_plier_r <= '0;
        end
      endcase
    end else if (mul_busy_r) begin
      mul_acc_r   <= {mul_acc_r[PROD_W-2:0], 1'b0}
                   + (mul_plier_r[MPLR_W-1] ? PROD_W'(mul_cand_r) : PROD_W'(0));
      mul_plier_r <= {mul_plier_r[MPLR_W-2:0], 1'b0};
    end
  end

  logic [PROD_W-1:0] p1_r;
  logic [PROD_W-1:0] p2_r;
  logic [DDEN_W-1:0] p3_r;
  logic [PROD_W-1:0] var_diff;

  always_ff @(posedge clk) begin
    if (cmd.cap_p1) p1_r <= mul_acc_r;
    if (cmd.cap_p2) p2_r <= mul_acc_r;
    if (cmd.cap_p3) p3_r <= mul_acc_r[DDEN_W-1:0];
  end

  assign var_diff = (p1_r >= p2_r) ? p1_r - p2_r : '0;

  // restoring divider, one quotient bit per cycle
  logic [DNUM_W-1:0]    div_num_r;
  logic [DNUM_W-1:0]    div_quo_r;
  logic [DDEN_W-1:0]    div_rem_r;
  logic [DDEN_W-1:0]    div_den_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic                 div_busy_r;
  logic [DDEN_W:0]      div_rem_sh;
  logic [DDEN_W:0]      div_rem_sub;
  logic                 div_ge;

  assign div_rem_sh  = {div_rem_r, div_num_r[DNUM_W-1]};
  assign div_ge      = div_rem_sh >= {1'b0, div_den_r};
  assign div_rem_sub = div_rem_sh - {1'b0, div_den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= '0;
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem_r <= '0;
      div_quo_r <= '0;
      unique case (cmd.div_sel)
        DIV_MEAN: begin
          div_num_r <= DNUM_W'({sum_mag, {MEAN_SHIFT{1'b0}}})
                     + DNUM_W'(cnt_r[CNT_W-1:1]);
          div_den_r <= DDEN_W'(cnt_r);
        end
        DIV_VAR: begin
          div_num_r <= {var_diff, {VAR_SHIFT{1'b0}}};
          div_den_r <= p3_r;
        end
      endcase
    end else if (div_busy_r) begin
      div_rem_r <= div_ge ? div_rem_sub[DDEN_W-1:0] : div_rem_sh[DDEN_W-1:0];
      div_num_r <= {div_num_r[DNUM_W-2:0], 1'b0};
      div_quo_r <= {div_quo_r[DNUM_W-2:0], div_ge};
    end
  end

  logic [SD_W-1:0]          mean_mag;
  logic signed [MEAN_W-1:0] mean_r;

  assign mean_mag = (div_quo_r > DNUM_W'(MEAN_LIM)) ? MEAN_LIM : div_quo_r[SD_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.cap_mean) begin
      mean_r <= sum_neg ? -MEAN_W'(mean_mag) : MEAN_W'(mean_mag);
    end
  end

  // bit-pair square root, two radicand bits per cycle
  logic [ROOT_W-1:0] root_x_r;
  logic [ROOT_W-1:0] root_res_r;
  logic [ROOT_W-1:0] root_bit_r;
  logic              root_sat_r;
  logic              root_busy_r;
  logic [ROOT_W-1:0] root_trial;
  logic [SD_W-1:0]   sd_val;

  assign root_trial = root_res_r + root_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_busy_r <= 1'b0;
    end else if (cmd.root_start) begin
      root_busy_r <= 1'b1;
    end else if (root_busy_r && root_bit_r[0]) begin
      root_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_start) begin
      root_x_r   <= div_quo_r[ROOT_W-1:0];
      root_sat_r <= |div_quo_r[DNUM_W-1:ROOT_W];
      root_res_r <= '0;
      root_bit_r <= ROOT_W'(1) << (ROOT_W - 2);
    end else if (root_busy_r) begin
      if (root_x_r >= root_trial) begin
        root_x_r   <= root_x_r - root_trial;
        root_res_r <= (root_res_r >> 1) + root_bit_r;
      end else begin
        root_res_r <= root_res_r >> 1;
      end
      root_bit_r <= root_bit_r >> 2;
    end
  end

  assign sd_val = (root_sat_r || root_res_r > ROOT_W'(SD_LIM)) ? SD_LIM
                : root_res_r[SD_W-1:0];

  // result register
  logic                     out_valid_r;
  logic signed [MEAN_W-1:0] mean_out_r;
  logic [SD_W-1:0]          sd_out_r;
  logic [CNT_W-1:0]         cnt_out_r;
  logic [STATUS_W-1:0]      status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cnt_out_r <= cnt_r;
      priority if (cnt_r == '0) begin
        status_r   <= ST_EMPTY;
        mean_out_r <= '0;
        sd_out_r   <= '0;
      end else if (sample_div && cnt_r == CNT_W'(1)) begin
        status_r   <= ST_SINGLE;
        mean_out_r <= mean_r;
        sd_out_r   <= '0;
      end else begin
        status_r   <= ovf_r ? ST_OVF : ST_OK;
        mean_out_r <= mean_r;
        sd_out_r   <= sd_val;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign mean_out   = mean_out_r;
  assign stddev_out = sd_out_r;
  assign count_out  = cnt_out_r;
  assign status     = status_r;

  assign sts.mul_busy  = mul_busy_r;
  assign sts.div_busy  = div_busy_r;
  assign sts.root_busy = root_busy_r;
  assign sts.out_free  = !out_valid_r || out_tready;

endmodule

@@ rtl/masked_mean_stddev_stream.sv @@
// Top level: register port, sequencer and datapath of the masked mean and deviation block.
`timescale 1ns / 1ps

// Takes one sample beat per cycle while a set is being gathered; beats with the include
// flag low only pass by. A beat with tlast closes the set: in_tready then stays low
// while one shift-add multiplier forms N*S2, S1*S1 and N*D (34 steps each), one
// restoring divider forms the mean and the variance (83 steps each) and a bit-pair square
// root gives the deviation (32 steps). If the previous result has not been taken by then,
// the block holds until it is. The result sits in an output register, so gathering of
// the next set goes on while it waits.

module masked_mean_stddev_stream (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [mms_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [mms_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [mms_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                         cfg_pready,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,   // first_value, second_value
  input  logic [0:0]                   in_tuser,   // include_req
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [71:0]                  out_tdata,  // mean_out, stddev_out, count_out, pad
  output logic [1:0]                   out_tuser   // status
);
  import mms_pkg::*;

  logic use_diff_r;
  logic sample_div_r;
  logic cfg_wr;
  logic cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_diff_r   <= 1'b0;
      sample_div_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_USE_DIFF:   use_diff_r   <= cfg_pwdata[0];
        REG_SAMPLE_DIV: sample_div_r <= cfg_pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_USE_DIFF:   cfg_prdata = DATA_W'(use_diff_r);
      REG_SAMPLE_DIV: cfg_prdata = DATA_W'(sample_div_r);
    endcase
  end

  cmd_t                     cmd;
  sts_t                     sts;
  logic signed [MEAN_W-1:0] mean_out;
  logic [SD_W-1:0]          stddev_out;
  logic [CNT_W-1:0]         count_out;
  logic [STATUS_W-1:0]      status;

  mms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  mms_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .use_diff     (use_diff_r),
    .sample_div   (sample_div_r),
    .first_value  ($signed(in_tdata[15:0])),
    .second_value ($signed(in_tdata[31:16])),
    .include_req  (in_tuser[0]),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .mean_out     (mean_out),
    .stddev_out   (stddev_out),
    .count_out    (count_out),
    .status       (status)
  );

  assign out_tdata = {6'b0, count_out, stddev_out, mean_out};
  assign out_tuser = status;

endmodule

@@ rtl/mms_chk.sv @@
// Port-level checks for the masked mean and deviation block, bound to the top level.
`timescale 1ns / 1ps

module mms_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import mms_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken right after closing beat");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tdata == 72'd0)
    else $error("empty set result not zero");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_SINGLE |-> out_tdata[48:25] == 24'd0
      && out_tdata[65:49] == 17'd1)
    else $error("single value result malformed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind masked_mean_stddev_stream mms_chk u_mms_chk (.*);

@@ tb/tb_top.sv @@
// Testbench for masked_mean_stddev_stream: streams masked sample sets and checks each result.
`timescale 1ns / 1ps

module tb_top;
  import mms_pkg::*;

  localparam int         SETTLE_CYCLES = 320;
  localparam logic [63:0] SQ_CAP       = (64'd1 << SSQ_W) - 64'd1;

  typedef struct {
    logic signed [MEAN_W-1:0] mean;
    logic [SD_W-1:0]          dev;
    logic [CNT_W-1:0]         count;
    logic [STATUS_W-1:0]      status;
  } stat_t;

  class stat_scoreboard;
    bit          diff_mode;
    bit          sample_mode;
    longint      run_sum;
    logic [63:0] run_sq;
    int          kept;
    bit          full_hit;
    stat_t       pending_stats[$];
    int          mismatches;
    int          results_seen;

    function new();
      diff_mode    = 1'b0;
      sample_mode  = 1'b1;
      mismatches   = 0;
      results_seen = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      run_sum  = 0;
      run_sq   = '0;
      kept     = 0;
      full_hit = 1'b0;
    endfunction

    function logic [63:0] isqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = '0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x   = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function void note_beat(logic signed [15:0] a, logic signed [15:0] b, logic inc,
                            logic last);
      longint       v;
      longint       mean;
      logic [63:0]  sq;
      logic [63:0]  s1;
      logic [63:0]  mag;
      logic [63:0]  root;
      logic [127:0] lhs;
      logic [127:0] rhs;
      logic [127:0] spread;
      logic [127:0] quo;
      int           divisor;
      stat_t        e;
      v = longint'(a);
      if (diff_mode) v = v - longint'(b);
      if (inc) begin
        if (kept >= int'(MAX_COUNT)) begin
          full_hit = 1'b1;
        end else begin
          sq      = 64'(v * v);
          kept    = kept + 1;
          run_sum = run_sum + v;
          if (run_sum > longint'(SUM_MAX)) run_sum = longint'(SUM_MAX);
          if (run_sum < longint'(SUM_MIN)) run_sum = longint'(SUM_MIN);
          run_sq = (sq > SQ_CAP - run_sq) ? SQ_CAP : run_sq + sq;
        end
      end
      if (!last) return;
      mean = 0;
      root = '0;
      if (kept == 0) begin
        e.status = ST_EMPTY;
      end else begin
        s1   = (run_sum < 0) ? 64'(-run_sum) : 64'(run_sum);
        mag  = ((s1 << 8) + 64'(kept / 2)) / 64'(kept);
        mean = (run_sum < 0) ? -longint'(mag) : longint'(mag);
        if (mean > longint'(MEAN_LIM)) mean = longint'(MEAN_LIM);
        if (mean < -longint'(MEAN_LIM)) mean = -longint'(MEAN_LIM);
        if (sample_mode && kept == 1) begin
          e.status = ST_SINGLE;
        end else begin
          divisor = sample_mode ? kept - 1 : kept;
          lhs     = 128'(kept) * 128'(run_sq);
          rhs     = 128'(s1) * 128'(s1);
          spread  = (lhs >= rhs) ? ((lhs - rhs) << 16) : 128'd0;
          quo     = spread / (128'(kept) * 128'(divisor));
          root    = (quo[127:64] != 0) ? 64'(SD_LIM) : isqrt(quo[63:0]);
          if (root > 64'(SD_LIM)) root = 64'(SD_LIM);
          e.status = full_hit ? ST_OVF : ST_OK;
        end
      end
      e.mean  = MEAN_W'(mean);
      e.dev   = root[SD_W-1:0];
      e.count = CNT_W'(kept);
      pending_stats.push_back(e);
      clear_sums();
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH result %0d %s: got %0d, expected %0d", results_seen, what, got, want);
      mismatches++;
    endtask

    task check_result(stat_t got);
      stat_t want;
      results_seen++;
      if (pending_stats.size() == 0) begin
        report("unexpected beat, status", got.status, -1);
        return;
      end
      want = pending_stats.pop_front();
      if (got.mean !== want.mean) report("mean", longint'(got.mean), longint'(want.mean));
      if (got.dev !== want.dev) report("stddev", got.dev, want.dev);
      if (got.count !== want.count) report("count", got.count, want.count);
      if (got.status !== want.status) report("status", got.status, want.status);
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [ADDR_W-1:0]   cfg_paddr;
  logic [DATA_W-1:0]   cfg_pwdata;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;
  logic                in_tvalid;
  logic                in_tready;
  logic [31:0]         in_tdata;   // first_value, second_value
  logic [0:0]          in_tuser;   // include_req
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [71:0]         out_tdata;  // mean_out, stddev_out, count_out, pad
  logic [1:0]          out_tuser;  // status

  stat_scoreboard sb = new();
  int in_idle_pct;
  int out_idle_pct;
  int sent;

  always #10 clk = ~clk;

  masked_mean_stddev_stream uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  task automatic cfg_write(input logic reg_idx, input logic [DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({reg_idx, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (reg_idx == REG_USE_DIFF) sb.diff_mode = val[0];
    else sb.sample_mode = val[0];
    @(posedge clk);
  endtask

  task automatic set_mode(input bit diff, input bit samp);
    cfg_write(REG_USE_DIFF, 32'(diff));
    cfg_write(REG_SAMPLE_DIV, 32'(samp));
  endtask

  task automatic send_beat(input logic [15:0] first, input logic [15:0] second,
                           input logic inc, input logic last);
    if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tdata  <= {second, first};
    in_tuser  <= inc;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_beat(first, second, inc, last);
    sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_set(input int len, input int inc_pct);
    for (int i = 0; i < len; i++)
      send_beat(pick_sample(), pick_sample(), $urandom_range(0, 99) < inc_pct, i == len - 1);
  endtask

  task automatic random_sets(input int n_items);
    int start;
    int pick;
    int len;
    int inc_pct;
    start = sent;
    while (sent - start < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) len = $urandom_range(20, 60);
      else if (pick <= 2) len = $urandom_range(1, 2);
      else len = $urandom_range(3, 12);
      pick = $urandom_range(0, 9);
      if (pick == 0) inc_pct = 0;
      else if (pick == 1) inc_pct = 100;
      else inc_pct = 70;
      send_set(len, inc_pct);
    end
  endtask

  task automatic run_phase(input bit diff, input bit samp, input int n_items, input int idle);
    set_mode(diff, samp);
    in_idle_pct  = idle;
    out_idle_pct = idle;
    random_sets(n_items);
    settle();
  endtask

  initial begin
    int stall;
    stat_t got;
    out_tready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
        got.mean   = out_tdata[MEAN_W-1:0];
        got.dev    = out_tdata[MEAN_W+SD_W-1:MEAN_W];
        got.count  = out_tdata[MEAN_W+SD_W+CNT_W-1:MEAN_W+SD_W];
        got.status = out_tuser;
        sb.check_result(got);
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
        stall = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    in_tlast     = 1'b0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    sent         = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty, single, extremes, ignored subtrahend
    set_mode(1'b0, 1'b1);
    send_beat(16'h1234, 16'h0000, 1'b0, 1'b1);
    send_beat(16'h7fff, 16'h8000, 1'b1, 1'b1);
    send_beat(16'h8000, 16'h5555, 1'b1, 1'b0);
    send_beat(16'h7fff, 16'h0000, 1'b1, 1'b0);
    send_beat(16'h0000, 16'h0000, 1'b0, 1'b0);
    send_beat(16'hffff, 16'haaaa, 1'b1, 1'b1);
    settle();

    set_mode(1'b1, 1'b0);
    send_beat(16'h7fff, 16'h8000, 1'b1, 1'b0);
    send_beat(16'h8000, 16'h7fff, 1'b1, 1'b1);
    send_beat(16'h0005, 16'h0003, 1'b1, 1'b1);
    send_beat(16'h8000, 16'h8000, 1'b1, 1'b0);
    send_beat(16'h0001, 16'h0001, 1'b0, 1'b1);
    settle();

    set_mode(1'b1, 1'b1);
    send_beat(16'h7fff, 16'h8000, 1'b1, 1'b0);
    send_beat(16'h8000, 16'h7fff, 1'b1, 1'b1);
    send_beat(16'h7fff, 16'h8000, 1'b1, 1'b1);
    send_beat(16'h8000, 16'h7fff, 1'b0, 1'b1);
    settle();

    run_phase(1'b0, 1'b1, 120, 30);
    run_phase(1'b1, 1'b0, 120, 0);
    run_phase(1'b0, 1'b0, 120, 30);
    run_phase(1'b1, 1'b1, 120, 30);
    run_phase(1'($urandom), 1'($urandom), 120, 30);
    run_phase(1'($urandom), 1'($urandom), 120, 0);

    if (sb.pending_stats.size() != 0) sb.report("results left over", 0,
                                                sb.pending_stats.size());
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
